FILE: rtl/core/refcounted_probe_table_core_defines.svh
// Assertion macros shared by the checker of the probe table core.
// Needs nothing else; the checker takes this file by include.
`ifndef REFCOUNTED_PROBE_TABLE_CORE_DEFINES_SVH
`define REFCOUNTED_PROBE_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define RPT_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("probe table assertion failed");

// Next-cycle implication, disabled while reset is held.
`define RPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("probe table assertion failed");

`endif

FILE: rtl/core/rpt_pkg.sv
// Shared types and constants of the reference-counted probe table.
// Used by the datapath, the controller, the top level and the checker.
package rpt_pkg;

    localparam int SLOTS       = 4;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int KEY_W       = 32;
    localparam int COUNT_W     = 16;
    localparam int ACTION_W    = 2;
    localparam int TAG_W       = 2;
    localparam int IN_TDATA_W  = ((ACTION_W + KEY_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((1 + SLOT_W + COUNT_W + 7) / 8) * 8;

    typedef logic [SLOT_W-1:0]  slot_idx_t;
    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [TAG_W-1:0]   tag_t;

    // Slot tags; the fourth code is never written and behaves as a tombstone.
    localparam tag_t TAG_EMPTY = 2'd0;
    localparam tag_t TAG_LIVE  = 2'd1;
    localparam tag_t TAG_TOMB  = 2'd2;

    localparam count_t COUNT_MAX = '1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD      = 2'd0,
        ACT_REMOVE   = 2'd1,
        ACT_CONTAINS = 2'd2,
        ACT_NONE     = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        FIN_FAIL,
        FIN_ADD_HIT,
        FIN_ADD_CLAIM,
        FIN_REMOVE,
        FIN_CONTAINS
    } fin_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic latch_fin;
        fin_t fin;
        logic commit;
    } rpt_cmd_t;

    typedef struct packed {
        logic    bad_item;
        action_t action;
        logic    live_hit;
        logic    is_empty;
        logic    free_any;
        logic    last_idx;
        logic    out_free;
    } rpt_status_t;

endpackage

FILE: rtl/core/refcounted_probe_table_core.sv
// Top level of the reference-counted probe table.
// Depends on rpt_pkg, rpt_ctrl and rpt_dp.
//
//  Channel   Direction  Word contents (lowest bit first)
//  s_*       in         action[1:0], key[33:2], zero pad to 40 bits
//  m_*       out        ok[0], slot_hit[2:1], ref_count[18:3], zero pad to 24 bits
//
// One word is taken in an idle cycle, then the slots are probed one per cycle
// from slot 0, and the finish step updates the slot and the output register.
// The output register lets a result wait while the next word is taken.
// A stalled output holds the finish cycle until the register frees up.
// Reset clears the slot store and the controller at once.
module refcounted_probe_table_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rpt_pkg::IN_TDATA_W-1:0]   s_tdata,   // action, key
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rpt_pkg::OUT_TDATA_W-1:0]  m_tdata    // ok, slot_hit, ref_count
);
    import rpt_pkg::*;

    rpt_cmd_t    cmd;
    rpt_status_t status;

    rpt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rpt_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: rtl/core/rpt_dp.sv
// Datapath of the probe table: slot store, probe pointer, finish update and
// the output word register. Depends on rpt_pkg; steered by rpt_ctrl.
module rpt_dp
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [rpt_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                             m_tready,
    input  rpt_pkg::rpt_cmd_t                cmd,
    output rpt_pkg::rpt_status_t             status,
    output logic                             m_tvalid,
    output logic [rpt_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import rpt_pkg::*;

    key_t      slot_key_reg   [SLOTS];
    tag_t      slot_tag_reg   [SLOTS];
    count_t    slot_count_reg [SLOTS];

    action_t   act_reg;
    key_t      key_reg;
    slot_idx_t idx_reg;
    logic      free_found_reg;
    slot_idx_t free_idx_reg;
    fin_t      fin_reg;
    slot_idx_t tgt_reg;

    logic      out_valid_reg;
    logic      out_ok_reg;
    slot_idx_t out_slot_reg;
    count_t    out_count_reg;

    tag_t      cur_tag;
    logic      live_hit;
    logic      non_live;
    slot_idx_t free_sel;
    count_t    tgt_count;
    logic      fin_ok;
    count_t    fin_count;
    logic      wr_count_en;
    logic      wr_tag_en;
    tag_t      wr_tag;
    logic      wr_key_en;

    // Probe of the slot under the pointer.
    always_comb
    begin
        cur_tag  = slot_tag_reg[idx_reg];
        live_hit = (cur_tag == TAG_LIVE) && (slot_key_reg[idx_reg] == key_reg);
        non_live = (cur_tag != TAG_LIVE);
        free_sel = free_found_reg ? free_idx_reg : idx_reg;
    end

    always_comb
    begin
        status.bad_item = (key_reg == '0) || (act_reg == ACT_NONE);
        status.action   = act_reg;
        status.live_hit = live_hit;
        status.is_empty = (cur_tag == TAG_EMPTY);
        status.free_any = free_found_reg || non_live;
        status.last_idx = (idx_reg == SLOT_W'(SLOTS - 1));
        status.out_free = !out_valid_reg || m_tready;
    end

    // Update of the chosen slot once the probe has settled.
    always_comb
    begin
        tgt_count   = slot_count_reg[tgt_reg];
        fin_ok      = 1'b0;
        fin_count   = '0;
        wr_count_en = 1'b0;
        wr_tag_en   = 1'b0;
        wr_tag      = TAG_LIVE;
        wr_key_en   = 1'b0;
        case (fin_reg)
            FIN_ADD_HIT:
            begin
                if (tgt_count != COUNT_MAX)
                begin
                    fin_ok      = 1'b1;
                    fin_count   = tgt_count + 1'b1;
                    wr_count_en = 1'b1;
                end
            end
            FIN_ADD_CLAIM:
            begin
                fin_ok      = 1'b1;
                fin_count   = count_t'(1);
                wr_count_en = 1'b1;
                wr_tag_en   = 1'b1;
                wr_key_en   = 1'b1;
            end
            FIN_REMOVE:
            begin
                if (tgt_count != '0)
                begin
                    fin_ok      = 1'b1;
                    fin_count   = tgt_count - 1'b1;
                    wr_count_en = 1'b1;
                    wr_tag_en   = 1'b1;
                    wr_tag      = (fin_count == '0) ? TAG_TOMB : TAG_LIVE;
                end
            end
            FIN_CONTAINS:
            begin
                fin_ok    = 1'b1;
                fin_count = tgt_count;
            end
            default:
            begin
                fin_ok = 1'b0;
            end
        endcase
    end

    // Slot store, cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_key_reg[i]   <= '0;
                slot_tag_reg[i]   <= TAG_EMPTY;
                slot_count_reg[i] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            if (wr_count_en)
            begin
                slot_count_reg[tgt_reg] <= fin_count;
            end
            if (wr_tag_en)
            begin
                slot_tag_reg[tgt_reg] <= wr_tag;
            end
            if (wr_key_en)
            begin
                slot_key_reg[tgt_reg] <= key_reg;
            end
        end
    end

    // Request and probe registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg        <= action_t'(s_tdata[ACTION_W-1:0]);
            key_reg        <= s_tdata[ACTION_W+KEY_W-1:ACTION_W];
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (non_live && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= idx_reg;
            end
        end
        if (cmd.latch_fin)
        begin
            fin_reg <= cmd.fin;
            tgt_reg <= (cmd.fin == FIN_ADD_CLAIM) ? free_sel : idx_reg;
        end
    end

    // Output word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_ok_reg    <= fin_ok;
            out_slot_reg  <= fin_ok ? tgt_reg : '0;
            out_count_reg <= fin_count;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_count_reg, out_slot_reg, out_ok_reg});

endmodule

FILE: rtl/core/rpt_ctrl.sv
// Controller of the probe table: sequences accept, probe and finish.
// Depends on rpt_pkg; drives rpt_dp through command and status structs.
module rpt_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  rpt_pkg::rpt_status_t status,
    output rpt_pkg::rpt_cmd_t    cmd
);
    import rpt_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   probe_done;
    fin_t   probe_fin;

    // What the current probe decides: stop with an outcome, or move on.
    always_comb
    begin
        probe_done = 1'b1;
        probe_fin  = FIN_FAIL;
        if (!status.bad_item)
        begin
            case (status.action)
                ACT_ADD:
                begin
                    if (status.live_hit)
                    begin
                        probe_fin = FIN_ADD_HIT;
                    end
                    else if (status.last_idx)
                    begin
                        probe_fin = status.free_any ? FIN_ADD_CLAIM : FIN_FAIL;
                    end
                    else
                    begin
                        probe_done = 1'b0;
                    end
                end
                ACT_REMOVE:
                begin
                    if (status.live_hit)
                    begin
                        probe_fin = FIN_REMOVE;
                    end
                    else if (!status.is_empty && !status.last_idx)
                    begin
                        probe_done = 1'b0;
                    end
                end
                ACT_CONTAINS:
                begin
                    if (status.live_hit)
                    begin
                        probe_fin = FIN_CONTAINS;
                    end
                    else if (!status.is_empty && !status.last_idx)
                    begin
                        probe_done = 1'b0;
                    end
                end
                default:
                begin
                    probe_fin = FIN_FAIL;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (probe_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.step      = 1'b0;
        cmd.latch_fin = 1'b0;
        cmd.fin       = probe_fin;
        cmd.commit    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_PROBE:
            begin
                cmd.step      = !probe_done;
                cmd.latch_fin = probe_done;
            end
            ST_FINISH:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/rpt_checker.sv
// Port-level checker for the probe table core, bound to the top level.
// Depends on rpt_pkg and the assertion macros header.
`include "refcounted_probe_table_core_defines.svh"

module rpt_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [rpt_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import rpt_pkg::*;

    localparam int RES_W = 1 + SLOT_W + COUNT_W;

    logic in_fire;
    logic fail_word;

    assign in_fire   = s_tvalid && s_tready;
    assign fail_word = m_tvalid && !m_tdata[0];

    // A failed result carries no slot and no count.
    `RPT_ASSERT(a_fail_clean, clk, rst_n, fail_word, m_tdata[RES_W-1:1] == '0)
    // The pad bits of the output word stay at zero.
    `RPT_ASSERT(a_out_pad, clk, rst_n, m_tvalid, m_tdata[OUT_TDATA_W-1:RES_W] == '0)
    // A word is worked on alone: ready drops after each accepted word.
    `RPT_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_fire, !s_tready)
    // A stalled result holds its value.
    `RPT_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind refcounted_probe_table_core rpt_checker u_rpt_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/probe_table_monitor.sv
// Watches both stream channels of the probe table core, keeps its own copy of the slot store
// and checks every result word against the outcome predicted for the matching input word.
// Depends on rpt_pkg for the field widths, the tag codes and the action codes.
module probe_table_monitor
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [rpt_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [rpt_pkg::OUT_TDATA_W-1:0] m_tdata,
    output int                              mismatches,
    output int                              in_flight,
    output int                              words_done,
    output int                              words_ok
);
    import rpt_pkg::*;

    typedef struct packed {
        logic      ok;
        slot_idx_t slot;
        count_t    count;
    } outcome_t;

    key_t      held_key   [SLOTS];
    tag_t      held_tag   [SLOTS];
    count_t    held_count [SLOTS];
    outcome_t  awaited_outcomes [$];
    outcome_t  got;
    outcome_t  want;
    int        errors_found = 0;
    int        outstanding  = 0;
    int        results_seen = 0;
    int        ok_seen      = 0;

    assign mismatches = errors_found;
    assign in_flight  = outstanding;
    assign words_done = results_seen;
    assign words_ok   = ok_seen;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        errors_found++;
    endtask

    // Applies one word to the local slot store and returns the outcome the block must give.
    function automatic outcome_t apply_word(input action_t act, input key_t k);
        outcome_t res;
        logic     settled;
        int       hit;
        res     = '0;
        settled = 1'b0;
        hit     = -1;
        if (k == '0 || act == ACT_NONE)
            return res;
        for (int i = 0; i < SLOTS; i++) begin
            if (!settled) begin
                if (held_tag[i] == TAG_LIVE && held_key[i] == k) begin
                    settled = 1'b1;
                    if (act == ACT_ADD && held_count[i] != COUNT_MAX) begin
                        held_count[i] = held_count[i] + 1'b1;
                        hit = i;
                    end
                    else if (act == ACT_REMOVE && held_count[i] != '0) begin
                        held_count[i] = held_count[i] - 1'b1;
                        if (held_count[i] == '0)
                            held_tag[i] = TAG_TOMB;
                        hit = i;
                    end
                    else if (act == ACT_CONTAINS)
                        hit = i;
                end
                // An empty slot ends the walk for remove and contains; tombstones are skipped.
                else if (held_tag[i] == TAG_EMPTY && act != ACT_ADD)
                    settled = 1'b1;
            end
        end
        if (!settled && act == ACT_ADD) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (!settled && held_tag[i] != TAG_LIVE) begin
                    settled       = 1'b1;
                    held_tag[i]   = TAG_LIVE;
                    held_key[i]   = k;
                    held_count[i] = count_t'(1);
                    hit           = i;
                end
            end
        end
        if (hit >= 0) begin
            res.ok    = 1'b1;
            res.slot  = slot_idx_t'(hit);
            res.count = held_count[hit];
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                held_key[i]   = '0;
                held_tag[i]   = TAG_EMPTY;
                held_count[i] = '0;
            end
            awaited_outcomes.delete();
            outstanding = 0;
        end
        else
        begin
            // Results are taken first: a word accepted on this edge cannot have its result yet.
            if (m_tvalid && m_tready)
            begin
                got.ok    = m_tdata[0];
                got.slot  = m_tdata[1 +: SLOT_W];
                got.count = m_tdata[1 + SLOT_W +: COUNT_W];
                results_seen++;
                if (got.ok)
                    ok_seen++;
                if (awaited_outcomes.size() == 0)
                    report_mismatch($sformatf("result word %0h with nothing outstanding", m_tdata));
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (got.ok != want.ok || got.slot != want.slot || got.count != want.count)
                        report_mismatch($sformatf(
                            "ok %0d slot %0d count %0d, expected ok %0d slot %0d count %0d",
                            got.ok, got.slot, got.count, want.ok, want.slot, want.count));
                end
            end
            if (s_tvalid && s_tready)
                awaited_outcomes.push_back(apply_word(action_t'(s_tdata[ACTION_W-1:0]),
                                                      s_tdata[ACTION_W +: KEY_W]));
            outstanding = awaited_outcomes.size();
        end
    end

endmodule

FILE: tb/refcounted_probe_table_core_tb.sv
// Top of the probe table testbench: clock, reset, input words and the verdict.
// Depends on rpt_pkg, the core refcounted_probe_table_core and probe_table_monitor.
module refcounted_probe_table_core_tb;
    import rpt_pkg::*;

    localparam int RANDOM_WORDS = 760;
    localparam int RAMP_WORDS   = 30;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   gaps_off;
    int                     mismatches;
    int                     in_flight;
    int                     words_done;
    int                     words_ok;
    key_t                   key_pool [6];

    refcounted_probe_table_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    probe_table_monitor table_watch
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .in_flight  (in_flight),
        .words_done (words_done),
        .words_ok   (words_ok)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #400_000;
        $display("Timed out with %0d words still outstanding.", in_flight);
        $display("FAILED: results differ");
        $finish;
    end

    initial
        m_tready = 1'b0;

    always @(negedge clk)
        m_tready <= gaps_off || ($urandom_range(99) >= 18);

    // Entered and left at a falling edge; valid stays high when words follow back to back.
    task automatic send_word(input action_t act, input key_t k);
        while (!gaps_off && $urandom_range(99) < 18)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({k, act});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained;
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (in_flight != 0)
            @(negedge clk);
    endtask

    initial
    begin
        action_t act;
        key_t    k;
        int      pick;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        gaps_off = 1'b0;
        for (int i = 0; i < 6; i++)
            key_pool[i] = $urandom_range(32'hFFFF_FFFF, 1);
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words: empty table, null key, unknown action, full table, tombstones.
        send_word(ACT_CONTAINS, 32'h0000_0001);
        send_word(ACT_REMOVE,   32'h0000_0001);
        send_word(ACT_ADD,      32'h0000_0000);
        send_word(ACT_REMOVE,   32'h0000_0000);
        send_word(ACT_CONTAINS, 32'h0000_0000);
        send_word(ACT_NONE,     32'h0000_0005);
        send_word(ACT_ADD,      32'hFFFF_FFFF);
        send_word(ACT_ADD,      32'hFFFF_FFFF);
        send_word(ACT_ADD,      32'h0000_0001);
        send_word(ACT_ADD,      32'h8000_0000);
        send_word(ACT_ADD,      32'h5555_AAAA);
        send_word(ACT_ADD,      32'h0000_0002);
        send_word(ACT_CONTAINS, 32'h5555_AAAA);
        send_word(ACT_CONTAINS, 32'h0000_0007);
        send_word(ACT_REMOVE,   32'h0000_0001);
        send_word(ACT_CONTAINS, 32'h0000_0001);
        send_word(ACT_REMOVE,   32'h0000_0001);
        send_word(ACT_ADD,      32'h0000_0007);
        send_word(ACT_NONE,     32'h0000_0007);
        send_word(ACT_REMOVE,   32'hFFFF_FFFF);
        send_word(ACT_REMOVE,   32'hFFFF_FFFF);
        send_word(ACT_REMOVE,   32'h0000_0007);
        send_word(ACT_REMOVE,   32'h8000_0000);
        send_word(ACT_REMOVE,   32'h5555_AAAA);
        send_word(ACT_CONTAINS, 32'h0000_0009);
        wait_drained;

        // Every slot is now a tombstone, so this key lands in slot 0 and its count is ramped up
        // and back down again, with no idling on either side.
        gaps_off = 1'b1;
        for (int n = 0; n < RAMP_WORDS; n++)
            send_word(ACT_ADD, 32'hA5A5_0001);
        send_word(ACT_CONTAINS, 32'hA5A5_0001);
        send_word(ACT_REMOVE,   32'hA5A5_0001);
        send_word(ACT_ADD,      32'hA5A5_0001);
        for (int n = 0; n < RAMP_WORDS; n++)
            send_word(ACT_REMOVE, 32'hA5A5_0001);
        send_word(ACT_CONTAINS, 32'hA5A5_0001);
        wait_drained;
        gaps_off = 1'b0;

        // Random traffic over a small key pool keeps the table churning between full and sparse.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 38)
                act = ACT_ADD;
            else if (pick < 76)
                act = ACT_REMOVE;
            else if (pick < 96)
                act = ACT_CONTAINS;
            else
                act = ACT_NONE;
            pick = $urandom_range(99);
            if (pick < 85)
                k = key_pool[$urandom_range(5)];
            else if (pick < 95)
                k = $urandom;
            else
                k = '0;
            send_word(act, k);
            if (n % 300 == 299)
                wait_drained;
        end
        wait_drained;
        repeat (12) @(negedge clk);

        $display("Run covered %0d words (%0d succeeded): directed corner cases, a count ramp",
                 words_done, words_ok);
        $display("up and back down, and random traffic over a small key pool.");
        if (mismatches == 0 && in_flight == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
